// ===== rtl/sidau_pkg.sv =====
// ----------------------------------------------------------------------------
// sidau_pkg
// Shared types, constants and helpers for the decimal text unit.
// ----------------------------------------------------------------------------
package sidau_pkg;

    localparam int VALUE_W    = 32;   // input integer width
    localparam int CHAR_W     = 8;    // ASCII code width
    localparam int NUM_DIGITS = 10;   // decimal digits of 2^31
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W      = 4;    // indexes 0..NUM_DIGITS-1
    localparam int CNT_W      = 5;    // counts one step per magnitude bit

    localparam logic [CNT_W-1:0]  CONV_LAST  = CNT_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    // One classified number: sign and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } num_entry_t;

    // Request from the front end into the queue.
    typedef struct packed {
        logic       valid;
        num_entry_t entry;
    } q_push_t;

    // Double-dabble correction: add 3 to every digit of 5 or more.
    function automatic bcd_t bcd_add3(input bcd_t bcd);
        bcd_t res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[i] >= 4'd5)
            begin
                res[i] = bcd[i] + 4'd3;
            end
        end
        return res;
    endfunction

    // Position of the most significant nonzero digit; 0 when all are zero.
    function automatic logic [IDX_W-1:0] bcd_msd(input bcd_t bcd);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[i] != '0)
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/sidau_front.sv =====
// ----------------------------------------------------------------------------
// sidau_front
// Input stage: takes a request, splits it into sign and magnitude.
// ----------------------------------------------------------------------------
module sidau_front
    import sidau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output q_push_t            push,
    input  logic               push_ready
);

    logic       valid_reg;
    num_entry_t entry_reg;
    logic       accept;

    assign s_axis_tready = !valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push.valid    = valid_reg;
    assign push.entry    = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Unsigned negate is exact for the most negative value too.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.neg <= s_axis_tdata[VALUE_W-1];
            entry_reg.mag <= s_axis_tdata[VALUE_W-1] ? ('0 - s_axis_tdata) : s_axis_tdata;
        end
    end

    // held entry is not dropped while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !push_ready |=> valid_reg && $stable(entry_reg))
        else $error("front entry lost while queue full");

endmodule

// ===== rtl/sidau_queue.sv =====
// ----------------------------------------------------------------------------
// sidau_queue
// Short FIFO between front end and formatter.
// ----------------------------------------------------------------------------
module sidau_queue
    import sidau_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_push_t    push,
    output logic       push_ready,
    output logic       pop_valid,
    output num_entry_t pop_entry,
    input  logic       pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    num_entry_t      mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

endmodule

// ===== rtl/sidau_back.sv =====
// ----------------------------------------------------------------------------
// sidau_back
// Formatter: bit-serial binary to BCD, then one character per cycle while the receiver accepts.
// ----------------------------------------------------------------------------
module sidau_back
    import sidau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  num_entry_t        pop_entry,
    output logic              pop_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CHAR_W-1:0] m_axis_tdata,   // [7:0] char_code
    output logic              m_axis_tlast    // last_char
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_LOCATE = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIGIT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg,   bin_next;
    bcd_t               bcd_reg,   bcd_next;
    logic               neg_reg,   neg_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [IDX_W-1:0]   idx_reg,   idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg,  out_char_next;
    logic               out_last_reg,  out_last_next;
    logic               slot_free;
    bcd_t               bcd_adj;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign pop_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;
    assign bcd_adj       = bcd_add3(bcd_reg);

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    bin_next   = pop_entry.mag;
                    neg_next   = pop_entry.neg;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // adjust, then shift the next magnitude bit in
                bcd_next = bcd_t'({bcd_adj[NUM_DIGITS-1:0]} << 1) | bcd_t'(bin_reg[VALUE_W-1]);
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                idx_next   = bcd_msd(bcd_reg);
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_reg[idx_reg]};
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_char_reg == CHAR_MINUS) |-> !out_last_reg)
        else $error("minus sign marked as last character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (idx_reg < IDX_W'(NUM_DIGITS)))
        else $error("digit index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) && (cnt_reg == CONV_LAST) |=> (state_reg == ST_LOCATE))
        else $error("conversion did not finish after all bits");

endmodule

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Formats a signed 32-bit integer as decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per number: tdata = value (two's complement).
//   m_axis returns the text one character per beat: tdata = ASCII code,
//   tlast marks the final character. Negative numbers start with '-', then
//   digits from most significant, no leading zeros; zero gives "0".
//   The most negative value prints as "-2147483648".
// Timing:
//   front register + queue + load + bit-serial double dabble (one
//   magnitude bit per cycle) + digit locate, then one character per cycle
//   while the receiver accepts, for N characters (1..11) per number. The
//   formatter takes a new number only once the last one is out. The 32-step
//   BCD conversion loop sets the rate.
//   The front end keeps accepting while the formatter works, until the
//   queue (QUEUE_DEPTH entries) and the front register are full.
// Reset clears all control state; no numbers or characters survive it.
// A stalled receiver holds the current character in the output register;
// the formatter waits and upstream backs up through the queue.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
    import sidau_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] char_code
    output logic               m_axis_tlast    // last_char
);

    q_push_t    push;
    logic       push_ready;
    logic       pop_valid;
    logic       pop_ready;
    num_entry_t pop_entry;

    // front end: request capture and sign/magnitude split
    sidau_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_ready    (push_ready)
    );

    // decoupling queue
    sidau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // back end: BCD conversion and character output
    sidau_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_entry     (pop_entry),
        .pop_ready     (pop_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed integer to decimal ASCII text unit.
// Every accepted number is formatted by a local model into the expected
// run of characters. Each character that leaves the unit is compared in
// order with that run. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import sidau_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 80;        // > first-character latency + 11 chars
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DECIMAL_BASE = 10;

    // One character of expected text.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata;    // [31:0] value
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [CHAR_W-1:0]  m_axis_tdata;    // [7:0] char_code
    logic               m_axis_tlast;    // last_char

    text_char_t pending_text[$];   // characters still owed by the unit, oldest first
    int         err_count   = 0;
    int         cycle_count = 0;
    bit         tx_idle_en  = 1'b1;    // sender inserts gaps between requests
    bit         rx_stall_en = 1'b1;    // receiver drops tready at random

    signed_int_to_decimal_ascii_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Zero half the time, otherwise mostly a short gap, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Decimal text of a two's complement value: optional '-', then digits
    // from most significant, no leading zeros. The magnitude is taken in
    // unsigned arithmetic so the most negative value comes out exact.
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic                  neg;
        logic [VALUE_W-1:0]    mag;
        logic [DIGIT_W-1:0]    digits[NUM_DIGITS];
        int                    nd;
        neg = value[VALUE_W-1];
        mag = neg ? (~value + 1'b1) : value;
        nd  = 0;
        do
        begin
            digits[nd] = DIGIT_W'(mag % DECIMAL_BASE);
            mag        = mag / DECIMAL_BASE;
            nd++;
        end
        while (mag != '0 && nd < NUM_DIGITS);
        if (neg)
        begin
            pending_text.push_back('{code: CHAR_MINUS, last: 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            pending_text.push_back('{code: CHAR_ZERO + CHAR_W'(digits[i]),
                                     last: (i == 0)});
        end
    endfunction

    // Random value with a random digit count, so short texts are as common
    // as full-length ones.
    function automatic logic [VALUE_W-1:0] pick_sized_value();
        int     nd;
        bit     neg;
        longint lo;
        longint hi;
        longint mag;
        longint p;
        nd  = $urandom_range(1, NUM_DIGITS);
        neg = $urandom_range(0, 1);
        p   = 1;
        for (int i = 1; i < nd; i++)
        begin
            p = p * DECIMAL_BASE;
        end
        lo = (nd == 1) ? 0 : p;
        hi = p * DECIMAL_BASE - 1;
        if (neg && hi > 64'sd2147483648)
        begin
            hi = 64'sd2147483648;
        end
        else if (!neg && hi > 64'sd2147483647)
        begin
            hi = 64'sd2147483647;
        end
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        return VALUE_W'(neg ? -mag : mag);
    endfunction

    // Sends one request and waits for its handshake. Returns at the accepting
    // edge with tvalid still high, so a following request with no gap keeps
    // tvalid up without a low pulse.
    task automatic send_number(input logic [VALUE_W-1:0] value);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;    // junk while idle, must be ignored
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_text(value);
    endtask

    // Receiver: tready held low for random stretches when stalls are enabled.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (rx_stall_en)
                begin
                    stall_left = pick_gap();
                end
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    // Character checker: every accepted character against the oldest expected.
    always @(posedge clk)
    begin : check_chars
        text_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_text.size() == 0)
            begin
                $error("unexpected character: char_code %0d last_char %0b",
                       m_axis_tdata, m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (m_axis_tdata !== want.code)
                begin
                    $error("char_code mismatch: expected %0d actual %0d",
                           want.code, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_char mismatch: expected %0b actual %0b",
                           want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Hang guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Boundaries, zero, the most negative value and a range of text lengths.
    task automatic test_directed();
        send_number(32'sd0);
        send_number(32'sd1);
        send_number(-32'sd1);
        send_number(32'sd9);
        send_number(32'sd10);
        send_number(-32'sd10);
        send_number(32'sd99);
        send_number(32'sd100);
        send_number(32'sd2147483647);
        send_number(32'h8000_0000);
        send_number(-32'sd2147483647);
        send_number(32'sd1000000000);
        send_number(-32'sd999999999);
        send_number(32'sd123456789);
        send_number(32'sd1000000);
        send_number(32'hFFFF_FFFE);
        send_number(32'h5555_5555);
        send_number(32'hAAAA_AAAA);
    endtask

    // Uniform 32-bit values: every input bit toggles, mostly long texts.
    task automatic test_random_full(input int count);
        repeat (count) send_number($urandom);
    endtask

    // Random digit count and sign.
    task automatic test_random_sized(input int count);
        repeat (count) send_number(pick_sized_value());
    endtask

    // No gaps and no stalls: the front end backs up against the formatter.
    task automatic test_full_rate(input int count);
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        repeat (count)
        begin
            if ($urandom_range(0, 1))
            begin
                send_number($urandom);
            end
            else
            begin
                send_number(pick_sized_value());
            end
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Sender at full rate, receiver stalling: backpressure through the queue.
    task automatic test_output_backpressure(input int count);
        tx_idle_en = 1'b0;
        repeat (count) send_number(pick_sized_value());
        tx_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_full(110);
        test_random_sized(130);
        test_full_rate(60);
        test_output_backpressure(60);
        s_axis_tvalid <= 1'b0;

        // All owed text in, then watch a while for stray characters.
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
